// ----- hdl/srs_pkg.sv -----
package srs_pkg;

    // Field and register widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 20;
    localparam int STATE_WIDTH  = 24;
    localparam int WET_WIDTH    = 17;
    localparam int COEF_FRAC    = 16;
    localparam int WET_FRAC     = 16;

    // Shared multiplier and accumulator widths
    localparam int OPA_W  = ((STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH) + 1;
    localparam int OPB_W  = (COEF_WIDTH > WET_WIDTH) ? COEF_WIDTH + 1 : WET_WIDTH + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [WET_WIDTH-1:0] WET_ONE = WET_WIDTH'(65536);

    localparam logic signed [COEF_WIDTH-1:0] COEF_X0_RST = COEF_WIDTH'(820);
    localparam logic signed [COEF_WIDTH-1:0] COEF_Y1_RST = COEF_WIDTH'(129387);
    localparam logic signed [COEF_WIDTH-1:0] COEF_Y2_RST = COEF_WIDTH'(-64882);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y2 = CFG_IDX_W'(2);

    // Microprogram step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_WAIT  = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_FILT0 = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_FILT1 = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_FILT2 = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_FILT3 = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_YOUT  = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_MIX0  = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_MIX1  = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_MIX2  = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_MOUT  = STEP_W'(9);
    localparam logic [STEP_W-1:0] ST_EMIT  = STEP_W'(10);

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_X_C0,
        MUL_P1_C1,
        MUL_P2_C2,
        MUL_Y_WET,
        MUL_X_DRY
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_NO_INPUT,
        JMP_LEFT,
        JMP_OUT_BUSY
    } jump_t;

    typedef struct packed {
        logic              accept;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              write_y;
        logic              write_mix;
        logic              emit;
        jump_t             jump;
        logic [STEP_W-1:0] target;
        logic              last;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   chan;
        logic   load_in;
        logic   load_out;
    } srs_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } srs_stat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_sample;
        logic signed [SAMPLE_WIDTH-1:0] right_sample;
        logic        [WET_WIDTH-1:0]    wet_level;
    } srs_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } srs_out_t;

    function automatic uword_t uword(input logic accept, input mul_sel_t mul_sel,
                                     input acc_op_t acc_op, input logic write_y,
                                     input logic write_mix, input logic emit,
                                     input jump_t jump, input logic [STEP_W-1:0] target,
                                     input logic last);
        uword_t w;
        w.accept    = accept;
        w.mul_sel   = mul_sel;
        w.acc_op    = acc_op;
        w.write_y   = write_y;
        w.write_mix = write_mix;
        w.emit      = emit;
        w.jump      = jump;
        w.target    = target;
        w.last      = last;
        return w;
    endfunction

    // Microprogram: one pass over the filter and mix per channel, left then right
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        unique case (step)
            ST_WAIT:  w = uword(1'b1, MUL_NONE,  ACC_HOLD, 1'b0, 1'b0, 1'b0,
                                JMP_NO_INPUT, ST_WAIT, 1'b0);
            ST_FILT0: w = uword(1'b0, MUL_X_C0,  ACC_HOLD, 1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_FILT1: w = uword(1'b0, MUL_P1_C1, ACC_LOAD, 1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_FILT2: w = uword(1'b0, MUL_P2_C2, ACC_ADD,  1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_FILT3: w = uword(1'b0, MUL_NONE,  ACC_ADD,  1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_YOUT:  w = uword(1'b0, MUL_NONE,  ACC_HOLD, 1'b1, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_MIX0:  w = uword(1'b0, MUL_Y_WET, ACC_HOLD, 1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_MIX1:  w = uword(1'b0, MUL_X_DRY, ACC_LOAD, 1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_MIX2:  w = uword(1'b0, MUL_NONE,  ACC_ADD,  1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b0);
            ST_MOUT:  w = uword(1'b0, MUL_NONE,  ACC_HOLD, 1'b0, 1'b1, 1'b0,
                                JMP_LEFT, ST_FILT0, 1'b0);
            ST_EMIT:  w = uword(1'b0, MUL_NONE,  ACC_HOLD, 1'b0, 1'b0, 1'b1,
                                JMP_OUT_BUSY, ST_EMIT, 1'b1);
            default:  w = uword(1'b0, MUL_NONE,  ACC_HOLD, 1'b0, 1'b0, 1'b0,
                                JMP_NONE, ST_WAIT, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/srs_useq.sv -----
module srs_useq (
    input  logic              clk,
    input  logic              rst_n,
    input  srs_pkg::srs_stat_t stat,
    output srs_pkg::srs_ctrl_t ctrl
);
    import srs_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              chan_reg, chan_next;
    uword_t            uw;
    logic              taken;

    assign uw = ucode_rom(step_reg);

    always_comb
    begin
        ctrl.uw       = uw;
        ctrl.chan     = chan_reg;
        ctrl.load_in  = uw.accept && stat.in_valid;
        ctrl.load_out = uw.emit && !stat.out_busy;
    end

    always_comb
    begin
        unique case (uw.jump)
            JMP_NONE:     taken = 1'b0;
            JMP_NO_INPUT: taken = !stat.in_valid;
            JMP_LEFT:     taken = !chan_reg;
            JMP_OUT_BUSY: taken = stat.out_busy;
            default:      taken = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (taken)
            step_next = uw.target;
        else if (uw.last)
            step_next = ST_WAIT;
        else
            step_next = STEP_W'(step_reg + 1'b1);
    end

    always_comb
    begin
        priority if (ctrl.load_in)
            chan_next = 1'b0;
        else if (uw.jump == JMP_LEFT && !chan_reg)
            chan_next = 1'b1;
        else
            chan_next = chan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
            chan_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            chan_reg <= chan_next;
        end
    end

`ifndef SYNTHESIS
    a_start_filter: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_in |=> (step_reg == ST_FILT0 && !chan_reg))
        else $error("accepted item did not start the left filter pass");
    a_emit_right: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_EMIT |-> chan_reg)
        else $error("result emitted before the right channel was done");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= ST_EMIT)
        else $error("step counter left the microprogram");
`endif

endmodule

// ----- hdl/srs_dp.sv -----
module srs_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  srs_pkg::srs_ctrl_t                     ctrl,
    input  srs_pkg::srs_in_t                       in_data,
    input  logic signed [srs_pkg::COEF_WIDTH-1:0]  coef_x0,
    input  logic signed [srs_pkg::COEF_WIDTH-1:0]  coef_y1,
    input  logic signed [srs_pkg::COEF_WIDTH-1:0]  coef_y2,
    output srs_pkg::srs_out_t                      out_data
);
    import srs_pkg::*;

    localparam int YSH_W = ACC_W - COEF_FRAC;
    localparam int MSH_W = ACC_W - WET_FRAC;
    localparam logic signed [YSH_W-1:0] Y_MAX =
        {{(YSH_W - STATE_WIDTH + 1){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
    localparam logic signed [YSH_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [MSH_W-1:0] M_MAX =
        {{(MSH_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [MSH_W-1:0] M_MIN = ~M_MAX;
    localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] M_HALF = ACC_W'(1) <<< (WET_FRAC - 1);

    logic signed [SAMPLE_WIDTH-1:0] xl_reg, xr_reg, mixl_reg, mixr_reg;
    logic        [WET_WIDTH-1:0]    wet_reg;
    logic signed [STATE_WIDTH-1:0]  lp1_reg, lp2_reg, rp1_reg, rp2_reg, y_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    srs_out_t                       out_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_sel;
    logic signed [STATE_WIDTH-1:0]  p1_sel, p2_sel;
    logic        [WET_WIDTH-1:0]    wet_in, dry;
    logic signed [OPA_W-1:0]        op_a;
    logic signed [OPB_W-1:0]        op_b;
    logic signed [ACC_W-1:0]        y_rnd, m_rnd;
    logic signed [YSH_W-1:0]        y_sh;
    logic signed [MSH_W-1:0]        m_sh;
    logic signed [STATE_WIDTH-1:0]  y_sat;
    logic signed [SAMPLE_WIDTH-1:0] m_sat;

    assign x_sel  = ctrl.chan ? xr_reg : xl_reg;
    assign p1_sel = ctrl.chan ? rp1_reg : lp1_reg;
    assign p2_sel = ctrl.chan ? rp2_reg : lp2_reg;
    assign wet_in = (in_data.wet_level > WET_ONE) ? WET_ONE : in_data.wet_level;
    assign dry    = WET_ONE - wet_reg;

    always_comb
    begin
        unique case (ctrl.uw.mul_sel)
            MUL_X_C0:
            begin
                op_a = OPA_W'(x_sel);
                op_b = OPB_W'(coef_x0);
            end
            MUL_P1_C1:
            begin
                op_a = OPA_W'(p1_sel);
                op_b = OPB_W'(coef_y1);
            end
            MUL_P2_C2:
            begin
                op_a = OPA_W'(p2_sel);
                op_b = OPB_W'(coef_y2);
            end
            MUL_Y_WET:
            begin
                op_a = OPA_W'(y_reg);
                op_b = OPB_W'($signed({1'b0, wet_reg}));
            end
            MUL_X_DRY:
            begin
                op_a = OPA_W'(x_sel);
                op_b = OPB_W'($signed({1'b0, dry}));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Round half up, then clip to the feedback and sample ranges
    assign y_rnd = acc_reg + Y_HALF;
    assign m_rnd = acc_reg + M_HALF;
    assign y_sh  = y_rnd[ACC_W-1:COEF_FRAC];
    assign m_sh  = m_rnd[ACC_W-1:WET_FRAC];

    always_comb
    begin
        priority if (y_sh > Y_MAX)
            y_sat = Y_MAX[STATE_WIDTH-1:0];
        else if (y_sh < Y_MIN)
            y_sat = Y_MIN[STATE_WIDTH-1:0];
        else
            y_sat = y_sh[STATE_WIDTH-1:0];
    end

    always_comb
    begin
        priority if (m_sh > M_MAX)
            m_sat = M_MAX[SAMPLE_WIDTH-1:0];
        else if (m_sh < M_MIN)
            m_sat = M_MIN[SAMPLE_WIDTH-1:0];
        else
            m_sat = m_sh[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            xl_reg  <= in_data.left_sample;
            xr_reg  <= in_data.right_sample;
            wet_reg <= wet_in;
        end
        prod_reg <= op_a * op_b;
        unique case (ctrl.uw.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
            default:  acc_reg <= acc_reg;
        endcase
        if (ctrl.uw.write_y)
            y_reg <= y_sat;
        if (ctrl.uw.write_mix)
        begin
            if (ctrl.chan)
                mixr_reg <= m_sat;
            else
                mixl_reg <= m_sat;
        end
        if (ctrl.load_out)
        begin
            out_reg.left_out  <= mixl_reg;
            out_reg.right_out <= mixr_reg;
        end
    end

    // Feedback history: advance one channel when its new value is ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp1_reg <= '0;
            lp2_reg <= '0;
            rp1_reg <= '0;
            rp2_reg <= '0;
        end
        else if (ctrl.uw.write_y)
        begin
            if (ctrl.chan)
            begin
                rp2_reg <= rp1_reg;
                rp1_reg <= y_sat;
            end
            else
            begin
                lp2_reg <= lp1_reg;
                lp1_reg <= y_sat;
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ----- hdl/stereo_two_pole_resonator.sv -----
// Stereo two-pole resonator with wet/dry mix.
// Input channel (in_valid, in_stall, in_data): one item carries a left and a
// right sample and a wet level; it is taken at a clock edge with in_valid high
// and in_stall low. Output channel (out_valid, out_stall, out_data): one item
// of two mixed samples per input item, held while out_stall is high.
// Configuration: cfg_we with cfg_index 0, 1, 2 writes coef_x0, coef_y1,
// coef_y2 from cfg_data; index 3 is ignored. Write only while idle.
// Sequencing: a microprogram drives one shared multiplier and accumulator,
// nine steps per channel, left then right, then an emit step. No new item is
// taken until the sequencer has emitted the last one and returned to its wait
// step. A stall on the output holds the sequencer in its emit step, with at
// most one finished item waiting in the output register.
// Reset clears the filter history and the handshake state and loads the
// default coefficients; the block is ready to accept in the first cycle.
module stereo_two_pole_resonator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  srs_pkg::srs_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output srs_pkg::srs_out_t                     out_data,
    input  logic                                  cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [srs_pkg::COEF_WIDTH-1:0]        cfg_data
);
    import srs_pkg::*;

    logic signed [COEF_WIDTH-1:0] coef_x0_reg, coef_y1_reg, coef_y2_reg;
    logic                         out_valid_reg, out_valid_next;
    srs_ctrl_t                    ctrl;
    srs_stat_t                    stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x0_reg <= COEF_X0_RST;
            coef_y1_reg <= COEF_Y1_RST;
            coef_y2_reg <= COEF_Y2_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_X0: coef_x0_reg <= $signed(cfg_data);
                CFG_COEF_Y1: coef_y1_reg <= $signed(cfg_data);
                CFG_COEF_Y2: coef_y2_reg <= $signed(cfg_data);
                default:     coef_x0_reg <= coef_x0_reg;
            endcase
        end
    end

    assign stat.in_valid = in_valid;
    assign stat.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        priority if (ctrl.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    srs_useq u_useq (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .ctrl (ctrl)
    );

    srs_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_data (in_data),
        .coef_x0 (coef_x0_reg),
        .coef_y1 (coef_y1_reg),
        .coef_y2 (coef_y2_reg),
        .out_data(out_data)
    );

    assign in_stall  = !ctrl.uw.accept;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.load_out))
        else $error("output item appeared without an emit step");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled output item was dropped");
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled output item changed");
`endif

endmodule

// ----- verif/srs_mix_checker.sv -----
`timescale 1ns / 1ps

module srs_mix_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  srs_pkg::srs_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  srs_pkg::srs_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::COEF_WIDTH-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import srs_pkg::*;

    logic signed [COEF_WIDTH-1:0]  gain_x0;
    logic signed [COEF_WIDTH-1:0]  gain_y1;
    logic signed [COEF_WIDTH-1:0]  gain_y2;
    logic signed [STATE_WIDTH-1:0] y_last [2];
    logic signed [STATE_WIDTH-1:0] y_prior [2];
    srs_out_t                      due_mix_q [$];

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One channel: filter, advance the history, then mix wet against dry
    function automatic logic signed [SAMPLE_WIDTH-1:0] resonate_channel(input int ch,
                                                                         input longint x,
                                                                         input longint wet);
        longint acc;
        longint y;
        longint mix;
        acc = longint'(gain_x0) * x
            + longint'(gain_y1) * longint'(y_last[ch])
            + longint'(gain_y2) * longint'(y_prior[ch]);
        y = clamp((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC, STATE_WIDTH);
        y_prior[ch] = y_last[ch];
        y_last[ch]  = STATE_WIDTH'(y);
        mix = wet * y + (longint'(WET_ONE) - wet) * x;
        mix = (mix + (longint'(1) << (WET_FRAC - 1))) >>> WET_FRAC;
        return SAMPLE_WIDTH'(clamp(mix, SAMPLE_WIDTH));
    endfunction

    function automatic srs_out_t resonate_pair(input srs_in_t item);
        srs_out_t res;
        longint   wet;
        // a wet level above one counts as fully wet
        wet = (item.wet_level > WET_ONE) ? longint'(WET_ONE) : longint'(item.wet_level);
        res.left_out  = resonate_channel(0, longint'(item.left_sample), wet);
        res.right_out = resonate_channel(1, longint'(item.right_sample), wet);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        srs_out_t due;
        if (!rst_n)
        begin
            gain_x0 = COEF_X0_RST;
            gain_y1 = COEF_Y1_RST;
            gain_y2 = COEF_Y2_RST;
            for (int c = 0; c < 2; c++)
            begin
                y_last[c]  = '0;
                y_prior[c] = '0;
            end
            due_mix_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COEF_X0: gain_x0 = cfg_data;
                    CFG_COEF_Y1: gain_y1 = cfg_data;
                    CFG_COEF_Y2: gain_y2 = cfg_data;
                    default: ;  // unknown index: drop the write
                endcase
            end
            if (in_valid && !in_stall)
                due_mix_q.insert(due_mix_q.size(), resonate_pair(in_data));
            if (out_valid && !out_stall)
            begin
                if (due_mix_q.size() == 0)
                begin
                    $error("unexpected output item: left_out %0d, right_out %0d",
                           out_data.left_out, out_data.right_out);
                    mismatches++;
                end
                else
                begin
                    due = due_mix_q.pop_front();
                    if (out_data.left_out !== due.left_out)
                    begin
                        $error("left_out: expected %0d, got %0d",
                               due.left_out, out_data.left_out);
                        mismatches++;
                    end
                    if (out_data.right_out !== due.right_out)
                    begin
                        $error("right_out: expected %0d, got %0d",
                               due.right_out, out_data.right_out);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = due_mix_q.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import srs_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 66;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam logic [WET_WIDTH-1:0]           WET_FULL   = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    srs_in_t               in_data;
    logic                  out_valid;
    logic                  out_stall;
    srs_out_t              out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COEF_WIDTH-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    bit tx_idling;
    bit rx_idling;
    bit hold_request;

    stereo_two_pole_resonator i_dut (.*);

    srs_mix_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic srs_in_t make_item(input int l, input int r, input int w);
        srs_in_t item;
        item.left_sample  = SAMPLE_WIDTH'(l);
        item.right_sample = SAMPLE_WIDTH'(r);
        item.wet_level    = WET_WIDTH'(w);
        return item;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic srs_in_t random_item();
        srs_in_t item;
        item.left_sample  = random_sample();
        item.right_sample = random_sample();
        case ($urandom_range(0, 7))
            0:       item.wet_level = '0;
            1:       item.wet_level = WET_ONE;
            2:       item.wet_level = WET_WIDTH'($urandom_range(int'(WET_ONE) + 1,
                                                               int'(WET_FULL)));
            default: item.wet_level = WET_WIDTH'($urandom_range(0, int'(WET_ONE)));
        endcase
        return item;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] extreme_coef();
        case ($urandom_range(0, 2))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            default: return '0;
        endcase
    endfunction

    // Offer one item until taken, then maybe go quiet for a burst
    task automatic push_item(input srs_in_t item);
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic [COEF_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_coefs(input logic [COEF_WIDTH-1:0] x0,
                             input logic [COEF_WIDTH-1:0] y1,
                             input logic [COEF_WIDTH-1:0] y2);
        drain();
        write_coef(CFG_COEF_X0, x0);
        write_coef(CFG_COEF_Y1, y1);
        write_coef(CFG_COEF_Y2, y2);
    endtask

    // Receiver: random stall bursts, or one long hold on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        logic signed [COEF_WIDTH-1:0] c0;
        logic signed [COEF_WIDTH-1:0] c1;
        logic signed [COEF_WIDTH-1:0] c2;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_COEF_X0;
        cfg_data     = '0;
        tx_idling    = 1'b0;
        rx_idling    = 1'b1;
        hold_request = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unknown register index must leave the default coefficients alone
        write_coef(CFG_UNUSED, COEF_MAX);
        push_item(make_item(0, 0, 0));
        push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, 0));
        push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, WET_ONE));
        push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, WET_ONE / 2));
        push_item(make_item(SAMPLE_MAX, SAMPLE_MAX, WET_FULL));
        push_item(make_item(-1, 1, WET_ONE + 1));
        push_item(make_item('h5555, 'hAAAA, 'h0AAAA));
        push_item(make_item('hAAAA, 'h5555, 'h15555));

        // drive the history into its limits and the mix past the sample range
        set_coefs(COEF_MAX, COEF_MAX, '0);
        repeat (3) push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, WET_ONE));
        repeat (3) push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, WET_ONE));
        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
        push_item(make_item(SAMPLE_MAX, SAMPLE_MAX, WET_ONE));
        push_item(make_item(SAMPLE_MIN, SAMPLE_MIN, WET_FULL));
        push_item(make_item(SAMPLE_MAX, SAMPLE_MIN, WET_ONE / 4));
        push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, WET_ONE));
        set_coefs(COEF_MIN, '0, COEF_MAX);
        push_item(make_item(SAMPLE_MIN, SAMPLE_MAX, WET_ONE));
        push_item(make_item(SAMPLE_MIN, SAMPLE_MIN, WET_FULL));

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    // resonator with random tuning
                    c0 = COEF_WIDTH'($urandom_range(0, 4000));
                    c1 = COEF_WIDTH'(int'($urandom_range(0, 240000)) - 120000);
                    c2 = COEF_WIDTH'(-int'($urandom_range(30000, 65000)));
                end
                1:
                begin
                    c0 = COEF_WIDTH'($urandom);
                    c1 = COEF_WIDTH'($urandom);
                    c2 = COEF_WIDTH'($urandom);
                end
                2:
                begin
                    c0 = extreme_coef();
                    c1 = extreme_coef();
                    c2 = extreme_coef();
                end
                default:
                begin
                    c0 = COEF_X0_RST;
                    c1 = COEF_Y1_RST;
                    c2 = COEF_Y2_RST;
                end
            endcase
            set_coefs(c0, c1, c2);
            tx_idling = (p != PHASES - 1) && (p % 3 != 2);
            rx_idling = (p != PHASES - 1) && (p % 3 != 1);
            if (p == 1)
            begin
                // hold the output long enough for the input to back up
                hold_request = 1'b1;
                tx_idling    = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 12)
                    tx_idling = 1'b1;
                if (p == 3 && n == PHASE_ITEMS / 2)
                    drain();
                push_item(random_item());
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #1_200_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/srs_pkg.sv
hdl/srs_useq.sv
hdl/srs_dp.sv
hdl/stereo_two_pole_resonator.sv
verif/srs_mix_checker.sv
verif/testbench.sv
